FILE: sv/tidcf_pkg.sv
// package for the trace identifier check formatter
// holds reciprocal constants, ascii codes and the check character map
// no dependencies
package tidcf_pkg;

  localparam int unsigned NUM_STAGES = 7;

  // floor(n / 10000) = (n * SERIAL_RECIP) >> SERIAL_SHIFT for 32-bit n
  localparam logic [31:0] SERIAL_RECIP = 32'hD1B7_1759;
  localparam int unsigned SERIAL_SHIFT = 45;
  localparam logic [13:0] SERIAL_MOD   = 14'd10000;

  // floor(n / 100) = ((n >> 2) * PREFIX_RECIP) >> 17 for 16-bit n
  localparam logic [12:0] PREFIX_RECIP = 13'd5243;
  localparam logic [6:0]  PREFIX_MOD   = 7'd100;

  // small divisions for values below 10000 (below 100 for DIV10_SMALL, below 256 for DIV11_RECIP)
  localparam logic [13:0] DIV1000_RECIP  = 14'd8389;
  localparam logic [12:0] DIV100_RECIP   = 13'd5243;
  localparam logic [12:0] DIV10_RECIP    = 13'd6554;
  localparam logic [6:0]  DIV10_SMALL    = 7'd103;
  localparam logic [9:0]  DIV11_RECIP    = 10'd745;
  localparam logic [3:0]  CHECK_MOD      = 4'd11;

  localparam logic [5:0] ASCII_ZERO6 = 6'd48;
  localparam logic [6:0] ASCII_ZERO7 = 7'd48;
  localparam logic [6:0] ASCII_X     = 7'd88;

  typedef logic [3:0] digit_t;

  // check map "0X987654321"
  function automatic logic [6:0] check_char_of(input logic [3:0] value);
    logic [6:0] ch;
    case (value)
      4'd0:    ch = ASCII_ZERO7;
      4'd1:    ch = ASCII_X;
      4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10:
        ch = ASCII_ZERO7 + 7'(CHECK_MOD - value);
      default: ch = ASCII_ZERO7;
    endcase
    return ch;
  endfunction

endpackage

FILE: sv/trace_id_check_formatter_unit.sv
// top level of the trace identifier check formatter
// seven-stage pipeline of narrow arithmetic with constant divisors
// depends on tidcf_pkg
//
// usage:
//   input channel in_valid / in_ready carries one request: id_prefix, id_serial.
//   output channel out_valid / out_ready carries one result per request: the
//   six ascii digits (prefix mod 100, serial mod 10000), the check value
//   (weights 7 down to 2, mod 11) and its check character.
//   each request passes through the stage registers in order, the last being
//   the result register that drives the outputs.
//   throughput: one request per cycle while out_ready is high; each stage holds
//   one request and the stages pass them on together, the widest step being the
//   32 x 32 multiply by the reciprocal of 10000 in the second stage.
//   reset clears all stage valid bits; the block then takes requests at once.
//   when the receiver stalls, the result register holds its request and stages
//   behind it keep filling until each holds a request; in_ready falls only
//   once all seven stages are full.
module trace_id_check_formatter_unit
  import tidcf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] id_prefix,
  input  logic [31:0] id_serial,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  check_char,
  output logic [3:0]  check_value,
  output logic [5:0]  prefix_tens,
  output logic [5:0]  prefix_ones,
  output logic [5:0]  serial_thousands,
  output logic [5:0]  serial_hundreds,
  output logic [5:0]  serial_tens,
  output logic [5:0]  serial_ones
);

  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] adv;

  always_comb begin
    adv[NUM_STAGES-1] = !vld[NUM_STAGES-1] || out_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // stage 1: input register
  logic [15:0] s1_prefix;
  logic [31:0] s1_serial;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_prefix <= id_prefix;
      s1_serial <= id_serial;
    end
  end

  // stage 2: reciprocal multiplies for the quotients
  logic [63:0] serial_prod;
  logic [26:0] prefix_prod;
  logic [18:0] s2_serial_q;
  logic [9:0]  s2_prefix_q;
  logic [15:0] s2_prefix;
  logic [31:0] s2_serial;

  assign serial_prod = 64'(s1_serial) * 64'(SERIAL_RECIP);
  assign prefix_prod = 27'(s1_prefix[15:2]) * 27'(PREFIX_RECIP);

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s2_serial_q <= serial_prod[SERIAL_SHIFT +: 19];
      s2_prefix_q <= prefix_prod[26:17];
      s2_prefix   <= s1_prefix;
      s2_serial   <= s1_serial;
    end
  end

  // stage 3: remainders
  logic [31:0] serial_rem;
  logic [15:0] prefix_rem;
  logic [13:0] s3_serial_rem;
  logic [6:0]  s3_prefix_rem;

  assign serial_rem = s2_serial - (32'(s2_serial_q) * 32'(SERIAL_MOD));
  assign prefix_rem = s2_prefix - (16'(s2_prefix_q) * 16'(PREFIX_MOD));

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s3_serial_rem <= serial_rem[13:0];
      s3_prefix_rem <= prefix_rem[6:0];
    end
  end

  // stage 4: serial quotients by 1000, 100 and 10
  logic [27:0] q1000_prod;
  logic [26:0] q100_prod;
  logic [26:0] q10_prod;
  digit_t      s4_thousands;
  logic [6:0]  s4_q100;
  logic [9:0]  s4_q10;
  logic [13:0] s4_serial_rem;
  logic [6:0]  s4_prefix_rem;

  assign q1000_prod = 28'(s3_serial_rem) * 28'(DIV1000_RECIP);
  assign q100_prod  = 27'(s3_serial_rem) * 27'(DIV100_RECIP);
  assign q10_prod   = 27'(s3_serial_rem) * 27'(DIV10_RECIP);

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s4_thousands  <= q1000_prod[26:23];
      s4_q100       <= q100_prod[25:19];
      s4_q10        <= q10_prod[25:16];
      s4_serial_rem <= s3_serial_rem;
      s4_prefix_rem <= s3_prefix_rem;
    end
  end

  // stage 5: digits
  logic [13:0] prefix_tens_prod;
  digit_t      ptens;
  logic [6:0]  hundreds_full;
  logic [9:0]  tens_full;
  logic [13:0] ones_full;
  logic [6:0]  pones_full;
  digit_t      s5_digit [6];

  assign prefix_tens_prod = 14'(s4_prefix_rem) * 14'(DIV10_SMALL);
  assign ptens            = prefix_tens_prod[13:10];
  assign hundreds_full    = s4_q100 - (7'(s4_thousands) * 7'd10);
  assign tens_full        = s4_q10 - (10'(s4_q100) * 10'd10);
  assign ones_full        = s4_serial_rem - (14'(s4_q10) * 14'd10);
  assign pones_full       = s4_prefix_rem - (7'(ptens) * 7'd10);

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s5_digit[0] <= ptens;
      s5_digit[1] <= pones_full[3:0];
      s5_digit[2] <= s4_thousands;
      s5_digit[3] <= hundreds_full[3:0];
      s5_digit[4] <= tens_full[3:0];
      s5_digit[5] <= ones_full[3:0];
    end
  end

  // stage 6: weighted sum
  logic [7:0] wsum;
  digit_t     s6_digit [6];
  logic [7:0] s6_sum;

  always_comb begin
    wsum = '0;
    for (int i = 0; i < 6; i++) begin
      wsum = wsum + (8'(s5_digit[i]) * 8'(7 - i));
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s6_sum   <= wsum;
      s6_digit <= s5_digit;
    end
  end

  // stage 7: mod 11, check character, result register
  logic [17:0] sum_prod;
  logic [4:0]  sum_q;
  logic [7:0]  chk_full;
  logic [3:0]  chk;
  logic [6:0]  res_char;
  logic [3:0]  res_value;
  digit_t      res_digit [6];

  assign sum_prod = 18'(s6_sum) * 18'(DIV11_RECIP);
  assign sum_q    = sum_prod[17:13];
  assign chk_full = s6_sum - (8'(sum_q) * 8'(CHECK_MOD));
  assign chk      = chk_full[3:0];

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      res_char  <= check_char_of(chk);
      res_value <= chk;
      res_digit <= s6_digit;
    end
  end

  assign check_char       = res_char;
  assign check_value      = res_value;
  assign prefix_tens      = ASCII_ZERO6 + 6'(res_digit[0]);
  assign prefix_ones      = ASCII_ZERO6 + 6'(res_digit[1]);
  assign serial_thousands = ASCII_ZERO6 + 6'(res_digit[2]);
  assign serial_hundreds  = ASCII_ZERO6 + 6'(res_digit[3]);
  assign serial_tens      = ASCII_ZERO6 + 6'(res_digit[4]);
  assign serial_ones      = ASCII_ZERO6 + 6'(res_digit[5]);

endmodule
